FILE: sv/xcr_pkg.sv
// Shared types and constants of the XMODEM checksum receiver.
package xcr_pkg;

   localparam int unsigned ADDR_BITS     = 20;
   localparam int unsigned PAYLOAD_BYTES = 128;
   localparam int unsigned HEADER_BYTES  = 2;
   localparam logic [7:0]  CHECKSUM_POS  = 8'(HEADER_BYTES + PAYLOAD_BYTES);

   // Item kinds on the request channel.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_WRITE = 2'd3;

   // Serial control characters.
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;

   // Transfer status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TIMEOUT   = 2'd1;
   localparam logic [1:0] ST_COMMS     = 2'd2;
   localparam logic [1:0] ST_PROG_FAIL = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_BASE_ADDRESS  = 2'd0;
   localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
   localparam logic [1:0] REG_PREAMBLE_WAIT = 2'd2;
   localparam logic [1:0] REG_BYTE_WAIT     = 2'd3;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_WAIT  = 5'b00010,
      MODE_BLOCK = 5'b00100,
      MODE_WRITE = 5'b01000,
      MODE_DONE  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [7:0]  retry_limit;
      logic [15:0] preamble_wait_ticks;
      logic [15:0] byte_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic                 tx_valid;
      logic [7:0]           tx_byte;
      logic                 data_valid;
      logic [7:0]           data_byte;
      logic [6:0]           data_index;
      logic                 commit;
      logic [ADDR_BITS-1:0] commit_address;
      logic                 done_res;
      logic [1:0]           status;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      rsp_type    res0;
      rsp_type    res1;
      logic [1:0] count;
   } step_out_type;

endpackage

FILE: sv/xcr_align.sv
// Reciprocal-multiply unit that aligns the base address down to a flash block.
module xcr_align
   import xcr_pkg::*;
#(
   parameter int unsigned FLASH_BLOCK_BYTES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [ADDR_BITS-1:0] load_value,
   output logic                 busy,
   output logic [ADDR_BITS-1:0] aligned
);

   // For every address below 2^ADDR_BITS the block index is (x * RECIP) >> SHIFT,
   // with SHIFT = ADDR_BITS + ceil(log2 of the block size) and RECIP = 2^SHIFT
   // divided by the block size, rounded up.
   localparam int unsigned     SHIFT      = ADDR_BITS + $clog2(FLASH_BLOCK_BYTES);
   localparam int unsigned     PW         = 2 * ADDR_BITS + 1;
   localparam longint unsigned RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(FLASH_BLOCK_BYTES) - 64'd1) / 64'(FLASH_BLOCK_BYTES);
   localparam logic [ADDR_BITS:0]   RECIP   = (ADDR_BITS+1)'(RECIP_WIDE);
   localparam logic [ADDR_BITS-1:0] DIVISOR = ADDR_BITS'(FLASH_BLOCK_BYTES);

   logic                 pending_ff;
   logic [ADDR_BITS-1:0] quot_ff;
   logic [ADDR_BITS-1:0] aligned_ff;
   logic [PW-1:0]        product;
   logic [ADDR_BITS-1:0] quot_in;

   // Block index of the new base address, registered when load is high.
   always_comb begin
      product = PW'(load_value) * PW'(RECIP);
      quot_in = ADDR_BITS'(product >> SHIFT);
   end

   // Then the block index scaled back up is registered as the aligned address.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         aligned_ff <= '0;
      end else if (load) begin
         pending_ff <= 1'b1;
         quot_ff    <= quot_in;
      end else if (pending_ff) begin
         pending_ff <= 1'b0;
         aligned_ff <= quot_ff * DIVISOR;
      end
   end

   assign busy    = pending_ff;
   assign aligned = aligned_ff;

endmodule

FILE: sv/xcr_ctrl.sv
// Protocol state registers and the per-word next-state and result logic.
module xcr_ctrl
   import xcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [1:0]           opcode,
   input  logic [7:0]           rx_byte,
   input  logic                 write_ok,
   input  cfg_type              cfg,
   input  logic [ADDR_BITS-1:0] base_aligned,
   output step_out_type         step_out
);

   mode_type             mode_ff,        mode_in;
   logic [7:0]           retries_ff,     retries_in;
   logic [15:0]          tick_ff,        tick_in;
   logic [7:0]           byte_pos_ff,    byte_pos_in;
   logic [7:0]           next_block_ff,  next_block_in;
   logic [7:0]           got_block_ff,   got_block_in;
   logic [7:0]           got_inv_ff,     got_inv_in;
   logic [7:0]           sum_ff,         sum_in;
   logic [ADDR_BITS-1:0] waddr_ff,       waddr_in;
   logic                 first_wait_ff,  first_wait_in;

   rsp_type     res0, res1;
   logic [1:0]  count;
   logic [16:0] tick_inc;
   logic [7:0]  retries_dec;
   logic        block_ok;

   function automatic rsp_type tx_word(input logic [7:0] ch);
      rsp_type r;
      r          = '0;
      r.tx_valid = 1'b1;
      r.tx_byte  = ch;
      return r;
   endfunction

   function automatic rsp_type done_word(input logic [1:0] st);
      rsp_type r;
      r          = '0;
      r.done_res = 1'b1;
      r.status   = st;
      return r;
   endfunction

   always_comb begin
      mode_in       = mode_ff;
      retries_in    = retries_ff;
      tick_in       = tick_ff;
      byte_pos_in   = byte_pos_ff;
      next_block_in = next_block_ff;
      got_block_in  = got_block_ff;
      got_inv_in    = got_inv_ff;
      sum_in        = sum_ff;
      waddr_in      = waddr_ff;
      first_wait_in = first_wait_ff;
      res0          = '0;
      res1          = '0;
      count         = 2'd0;

      tick_inc    = {1'b0, tick_ff} + 17'd1;
      retries_dec = (retries_ff != 8'd0) ? retries_ff - 8'd1 : 8'd0;
      block_ok    = (got_block_ff == next_block_ff) && (got_inv_ff == ~got_block_ff)
                    && (rx_byte == sum_ff);

      if (fire) begin
         unique case (opcode)
            OP_START: begin
               waddr_in      = base_aligned;
               next_block_in = 8'd1;
               first_wait_in = 1'b1;
               byte_pos_in   = 8'd0;
               sum_in        = 8'd0;
               got_block_in  = 8'd0;
               got_inv_in    = 8'd0;
               tick_in       = 16'd0;
               retries_in    = cfg.retry_limit;
               count         = 2'd1;
               if (cfg.retry_limit == 8'd0) begin
                  mode_in = MODE_DONE;
                  res0    = done_word(ST_TIMEOUT);
               end else begin
                  mode_in = MODE_WAIT;
                  res0    = tx_word(CH_NAK);
               end
            end
            OP_BYTE: begin
               if (mode_ff == MODE_WAIT) begin
                  first_wait_in = 1'b0;
                  if (rx_byte == CH_SOH) begin
                     mode_in     = MODE_BLOCK;
                     byte_pos_in = 8'd0;
                     sum_in      = 8'd0;
                     tick_in     = 16'd0;
                  end else if (rx_byte == CH_EOT) begin
                     mode_in = MODE_DONE;
                     res0    = tx_word(CH_ACK);
                     res1    = done_word(ST_OK);
                     count   = 2'd2;
                  end else begin
                     mode_in = MODE_DONE;
                     res0    = done_word(ST_COMMS);
                     count   = 2'd1;
                  end
               end else if (mode_ff == MODE_BLOCK) begin
                  tick_in = 16'd0;
                  if (byte_pos_ff == 8'd0) begin
                     got_block_in = rx_byte;
                     byte_pos_in  = byte_pos_ff + 8'd1;
                  end else if (byte_pos_ff == 8'd1) begin
                     got_inv_in  = rx_byte;
                     byte_pos_in = byte_pos_ff + 8'd1;
                  end else if (byte_pos_ff < CHECKSUM_POS) begin
                     res0.data_valid = 1'b1;
                     res0.data_byte  = rx_byte;
                     res0.data_index = 7'(byte_pos_ff - 8'(HEADER_BYTES));
                     count           = 2'd1;
                     sum_in          = sum_ff + rx_byte;
                     byte_pos_in     = byte_pos_ff + 8'd1;
                  end else if (block_ok) begin
                     res0.commit         = 1'b1;
                     res0.commit_address = waddr_ff;
                     count               = 2'd1;
                     mode_in             = MODE_WRITE;
                  end else begin
                     // Bad block: NAK, then fresh preamble waits or a timeout end.
                     res0       = tx_word(CH_NAK);
                     retries_in = cfg.retry_limit;
                     tick_in    = 16'd0;
                     if (cfg.retry_limit == 8'd0) begin
                        mode_in = MODE_DONE;
                        res1    = done_word(ST_TIMEOUT);
                        count   = 2'd2;
                     end else begin
                        mode_in = MODE_WAIT;
                        count   = 2'd1;
                     end
                  end
               end
            end
            OP_TICK: begin
               if (mode_ff == MODE_WAIT) begin
                  if (tick_inc >= {1'b0, cfg.preamble_wait_ticks}) begin
                     tick_in    = 16'd0;
                     retries_in = retries_dec;
                     if (retries_dec == 8'd0) begin
                        mode_in = MODE_DONE;
                        res0    = done_word(ST_TIMEOUT);
                        count   = 2'd1;
                     end else if (first_wait_ff) begin
                        res0  = tx_word(CH_NAK);
                        count = 2'd1;
                     end
                  end else begin
                     tick_in = tick_inc[15:0];
                  end
               end else if (mode_ff == MODE_BLOCK) begin
                  if (tick_inc >= {1'b0, cfg.byte_wait_ticks}) begin
                     // A byte timeout inside a block counts as a bad block.
                     res0       = tx_word(CH_NAK);
                     retries_in = cfg.retry_limit;
                     tick_in    = 16'd0;
                     if (cfg.retry_limit == 8'd0) begin
                        mode_in = MODE_DONE;
                        res1    = done_word(ST_TIMEOUT);
                        count   = 2'd2;
                     end else begin
                        mode_in = MODE_WAIT;
                        count   = 2'd1;
                     end
                  end else begin
                     tick_in = tick_inc[15:0];
                  end
               end
            end
            OP_WRITE: begin
               if (mode_ff == MODE_WRITE) begin
                  if (write_ok) begin
                     waddr_in      = waddr_ff + ADDR_BITS'(PAYLOAD_BYTES);
                     next_block_in = next_block_ff + 8'd1;
                     res0          = tx_word(CH_ACK);
                     retries_in    = cfg.retry_limit;
                     tick_in       = 16'd0;
                     if (cfg.retry_limit == 8'd0) begin
                        mode_in = MODE_DONE;
                        res1    = done_word(ST_TIMEOUT);
                        count   = 2'd2;
                     end else begin
                        mode_in = MODE_WAIT;
                        count   = 2'd1;
                     end
                  end else begin
                     mode_in       = MODE_DONE;
                     res0          = tx_word(CH_NAK);
                     res1          = tx_word(CH_CAN);
                     res1.done_res = 1'b1;
                     res1.status   = ST_PROG_FAIL;
                     count         = 2'd2;
                  end
               end
            end
         endcase
      end

      if (count == 2'd2) begin
         res1.last = 1'b1;
      end else if (count == 2'd1) begin
         res0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         retries_ff    <= 8'd0;
         tick_ff       <= 16'd0;
         byte_pos_ff   <= 8'd0;
         next_block_ff <= 8'd1;
         got_block_ff  <= 8'd0;
         got_inv_ff    <= 8'd0;
         sum_ff        <= 8'd0;
         waddr_ff      <= '0;
         first_wait_ff <= 1'b1;
      end else begin
         mode_ff       <= mode_in;
         retries_ff    <= retries_in;
         tick_ff       <= tick_in;
         byte_pos_ff   <= byte_pos_in;
         next_block_ff <= next_block_in;
         got_block_ff  <= got_block_in;
         got_inv_ff    <= got_inv_in;
         sum_ff        <= sum_in;
         waddr_ff      <= waddr_in;
         first_wait_ff <= first_wait_in;
      end
   end

   assign step_out.res0  = res0;
   assign step_out.res1  = res1;
   assign step_out.count = count;

endmodule

FILE: sv/xcr_outq.sv
// Four-entry result queue: up to two words in a cycle, one out when ready.
module xcr_outq
   import xcr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  step_out_type step_out,
   output logic         space_ok,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_type      out_word
);

   rsp_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] cnt_ff,    cnt_in;
   logic                 pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];
   // Room for the largest burst one word can cause.
   assign space_ok  = (cnt_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(step_out.count);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
      cnt_in    = cnt_ff + QCNT_BITS'(step_out.count) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (step_out.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= step_out.res0;
      end
      if (step_out.count == 2'd2) begin
         mem_ff[wr_ptr_ff + QPTR_BITS'(1)] <= step_out.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: sv/xmodem_checksum_receiver.sv
// Top level of the XMODEM checksum receiver with its configuration registers.
//
// The request stream carries one word per event: a start, a byte from the
// serial line, a time tick or the result of a flash write (kind in tuser).
// Each word updates the protocol state in the cycle it is accepted and may
// cause up to two result words: a control byte to send, a provisional payload
// byte, a commit request for a verified block, or the end of the transfer
// with its status. tlast marks the last result word caused by a request word.
// Results are written into the result queue as the request word is accepted.
// One request word is taken per cycle as long as the result queue has room
// for two words and no alignment is pending, so the receiver sustains one
// word per cycle while the response side keeps up. When the response side
// stalls, results pile up in the four-entry queue and req_tready falls once
// fewer than two slots are left; nothing is lost. Writing base_address starts
// a two-step alignment to the flash block size by reciprocal multiplication;
// req_tready stays low while the aligned address is formed.
// Reset clears the protocol state to idle, loads the register defaults and
// empties the queue; no alignment pass is needed after reset.
module xmodem_checksum_receiver
   import xcr_pkg::*;
#(
   parameter int unsigned FLASH_BLOCK_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte [7:0], write_ok [8], zero fill
   input  logic [1:0]  req_tuser,   // opcode [1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // tx_byte [7:0], data_byte [15:8],
                                    // data_index [22:16], commit_address [42:23],
                                    // status [44:43], zero fill
   output logic [3:0]  rsp_tuser,   // tx_valid [0], data_valid [1], commit [2],
                                    // done_res [3]
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [ADDR_BITS-1:0] base_address_ff;
   logic [7:0]           retry_limit_ff;
   logic [15:0]          preamble_wait_ff;
   logic [15:0]          byte_wait_ff;

   logic                 csr_write;
   logic [1:0]           reg_index;
   logic                 base_load;
   logic                 align_busy;
   logic [ADDR_BITS-1:0] base_aligned;
   logic                 space_ok;
   logic                 req_fire;
   cfg_type              cfg;
   step_out_type         step_out;
   rsp_type              head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];
   assign base_load  = csr_write && (reg_index == REG_BASE_ADDRESS);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff  <= '0;
         retry_limit_ff   <= 8'd10;
         preamble_wait_ff <= 16'd5000;
         byte_wait_ff     <= 16'd1000;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_BASE_ADDRESS:  base_address_ff  <= csr_pwdata[ADDR_BITS-1:0];
            REG_RETRY_LIMIT:   retry_limit_ff   <= csr_pwdata[7:0];
            REG_PREAMBLE_WAIT: preamble_wait_ff <= csr_pwdata[15:0];
            REG_BYTE_WAIT:     byte_wait_ff     <= csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_BASE_ADDRESS:  csr_prdata = {{(32-ADDR_BITS){1'b0}}, base_address_ff};
         REG_RETRY_LIMIT:   csr_prdata = {24'd0, retry_limit_ff};
         REG_PREAMBLE_WAIT: csr_prdata = {16'd0, preamble_wait_ff};
         REG_BYTE_WAIT:     csr_prdata = {16'd0, byte_wait_ff};
      endcase
   end

   assign cfg.retry_limit         = retry_limit_ff;
   assign cfg.preamble_wait_ticks = preamble_wait_ff;
   assign cfg.byte_wait_ticks     = byte_wait_ff;

   // The aligned start address is worked out once per base_address write.
   xcr_align #(
      .FLASH_BLOCK_BYTES(FLASH_BLOCK_BYTES)
   ) u_align (
      .clock      (clock),
      .reset      (reset),
      .load       (base_load),
      .load_value (csr_pwdata[ADDR_BITS-1:0]),
      .busy       (align_busy),
      .aligned    (base_aligned)
   );

   assign req_tready = space_ok && !align_busy;
   assign req_fire   = req_tvalid && req_tready;

   xcr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fire         (req_fire),
      .opcode       (req_tuser),
      .rx_byte      (req_tdata[7:0]),
      .write_ok     (req_tdata[8]),
      .cfg          (cfg),
      .base_aligned (base_aligned),
      .step_out     (step_out)
   );

   xcr_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .step_out  (step_out),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (head)
   );

   assign rsp_tdata = {3'd0, head.status, head.commit_address, head.data_index,
                       head.data_byte, head.tx_byte};
   assign rsp_tuser = {head.done_res, head.commit, head.data_valid, head.tx_valid};
   assign rsp_tlast = head.last;

endmodule

FILE: dv/tb_xmodem_checksum_receiver.sv
// Self-checking testbench of the XMODEM checksum receiver: stream stimulus, register writes, checks.
`timescale 1ns / 100ps

module tb_xmodem_checksum_receiver;
   import xcr_pkg::*;

   localparam int unsigned FLASH_BLOCK = 1024;

   // Clock, reset and every input of the block start at known values.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // rx_byte [7:0], write_ok [8], zero fill
   logic [1:0]  req_tuser   = OP_TICK;   // opcode [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;   // tx_byte [7:0], data_byte [15:8], data_index [22:16],
                             // commit_address [42:23], status [44:43], zero fill
   logic [3:0]  rsp_tuser;   // tx_valid [0], data_valid [1], commit [2], done_res [3]
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   xmodem_checksum_receiver #(
      .FLASH_BLOCK_BYTES(FLASH_BLOCK)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #4 clock = ~clock;

   // Percentages of cycles in which the sender holds back a word and the
   // receiver deasserts tready.
   int req_idle_pct = 21;
   int rsp_idle_pct = 65;
   int fail_count   = 0;
   int word_count   = 0;
   // Word count after which a random transfer starts no new block.
   int word_budget  = 0;

   // Response words the receiver is expected to produce, oldest first.
   rsp_type pending_responses[$];
   rsp_type step_words[$];

   // Register copies as the block should hold them.
   logic [19:0] cfg_base           = '0;
   logic [7:0]  cfg_retries        = 8'd10;
   logic [15:0] cfg_preamble_ticks = 16'd5000;
   logic [15:0] cfg_byte_ticks     = 16'd1000;

   // Protocol state of the receiver as predicted.
   mode_type    rx_mode      = MODE_IDLE;
   logic [7:0]  retries_left = '0;
   logic [15:0] tick_count   = '0;
   logic [7:0]  byte_pos     = '0;
   logic [7:0]  expect_blk   = 8'd1;
   logic [7:0]  got_blk      = '0;
   logic [7:0]  got_blk_inv  = '0;
   logic [7:0]  blk_sum      = '0;
   logic [19:0] write_addr   = '0;
   logic        first_wait   = 1'b1;

   // ------------------------------------------------------------------
   // Prediction of the receiver's responses.
   // ------------------------------------------------------------------
   function automatic void emit_ctrl(input logic [7:0] ch);
      rsp_type w = '0;
      w.tx_valid = 1'b1;
      w.tx_byte  = ch;
      step_words.push_back(w);
   endfunction

   function automatic void end_transfer(input logic [1:0] st);
      rsp_type w = '0;
      w.done_res = 1'b1;
      w.status   = st;
      step_words.push_back(w);
      rx_mode = MODE_DONE;
   endfunction

   // A fresh series of preamble waits; with no retries it ends at once.
   function automatic void enter_wait();
      rx_mode      = MODE_WAIT;
      retries_left = cfg_retries;
      tick_count   = '0;
      if (retries_left == 8'd0) end_transfer(ST_TIMEOUT);
   endfunction

   function automatic void reject_block();
      emit_ctrl(CH_NAK);
      enter_wait();
   endfunction

   // Advances the predicted state by one accepted request word and queues
   // the response words it causes, the last one marked.
   function automatic void xmodem_rx_step(input logic [1:0] op, input logic [7:0] rx,
                                          input logic wok);
      rsp_type w;
      logic    good;
      step_words.delete();
      case (op)
         OP_START: begin
            // A start restarts the transfer whatever the receiver was doing.
            write_addr   = 20'(cfg_base - cfg_base % FLASH_BLOCK);
            expect_blk   = 8'd1;
            first_wait   = 1'b1;
            byte_pos     = '0;
            blk_sum      = '0;
            got_blk      = '0;
            got_blk_inv  = '0;
            rx_mode      = MODE_WAIT;
            retries_left = cfg_retries;
            tick_count   = '0;
            if (retries_left == 8'd0) end_transfer(ST_TIMEOUT);
            else emit_ctrl(CH_NAK);
         end
         OP_BYTE: begin
            if (rx_mode == MODE_WAIT) begin
               first_wait = 1'b0;
               if (rx == CH_SOH) begin
                  rx_mode    = MODE_BLOCK;
                  byte_pos   = '0;
                  blk_sum    = '0;
                  tick_count = '0;
               end else if (rx == CH_EOT) begin
                  emit_ctrl(CH_ACK);
                  end_transfer(ST_OK);
               end else begin
                  end_transfer(ST_COMMS);
               end
            end else if (rx_mode == MODE_BLOCK) begin
               tick_count = '0;
               if (byte_pos == 8'd0) begin
                  got_blk  = rx;
                  byte_pos = byte_pos + 8'd1;
               end else if (byte_pos == 8'd1) begin
                  got_blk_inv = rx;
                  byte_pos    = byte_pos + 8'd1;
               end else if (byte_pos < CHECKSUM_POS) begin
                  w            = '0;
                  w.data_valid = 1'b1;
                  w.data_byte  = rx;
                  w.data_index = 7'(byte_pos - HEADER_BYTES);
                  step_words.push_back(w);
                  blk_sum  = blk_sum + rx;
                  byte_pos = byte_pos + 8'd1;
               end else begin
                  good = (got_blk == expect_blk) && (got_blk_inv == ~got_blk) &&
                         (rx == blk_sum);
                  if (good) begin
                     w                = '0;
                     w.commit         = 1'b1;
                     w.commit_address = write_addr;
                     step_words.push_back(w);
                     rx_mode = MODE_WRITE;
                  end else begin
                     reject_block();
                  end
               end
            end
         end
         OP_TICK: begin
            if (rx_mode == MODE_WAIT) begin
               tick_count = tick_count + 16'd1;
               if (tick_count >= cfg_preamble_ticks) begin
                  tick_count = '0;
                  if (retries_left > 8'd0) retries_left = retries_left - 8'd1;
                  // NAK is repeated on timeout only until the sender has spoken.
                  if (retries_left == 8'd0) end_transfer(ST_TIMEOUT);
                  else if (first_wait) emit_ctrl(CH_NAK);
               end
            end else if (rx_mode == MODE_BLOCK) begin
               // A silent line inside a block counts as a bad block.
               tick_count = tick_count + 16'd1;
               if (tick_count >= cfg_byte_ticks) reject_block();
            end
         end
         OP_WRITE: begin
            if (rx_mode == MODE_WRITE) begin
               if (wok) begin
                  write_addr = 20'(write_addr + PAYLOAD_BYTES);
                  expect_blk = expect_blk + 8'd1;
                  emit_ctrl(CH_ACK);
                  enter_wait();
               end else begin
                  emit_ctrl(CH_NAK);
                  w          = '0;
                  w.tx_valid = 1'b1;
                  w.tx_byte  = CH_CAN;
                  w.done_res = 1'b1;
                  w.status   = ST_PROG_FAIL;
                  step_words.push_back(w);
                  rx_mode = MODE_DONE;
               end
            end
         end
      endcase
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[i]) pending_responses.push_back(step_words[i]);
   endfunction

   // ------------------------------------------------------------------
   // Response side: random back-pressure and the checker.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Every accepted response word is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tx_valid       = rsp_tuser[0];
         got.tx_byte        = rsp_tdata[7:0];
         got.data_valid     = rsp_tuser[1];
         got.data_byte      = rsp_tdata[15:8];
         got.data_index     = rsp_tdata[22:16];
         got.commit         = rsp_tuser[2];
         got.commit_address = rsp_tdata[42:23];
         got.done_res       = rsp_tuser[3];
         got.status         = rsp_tdata[44:43];
         got.last           = rsp_tlast;
         if (pending_responses.size() == 0) begin
            $error("response word with no expectation pending");
            fail_count++;
         end else begin
            want = pending_responses.pop_front();
            check_field("tx_valid", want.tx_valid, got.tx_valid);
            check_field("tx_byte", want.tx_byte, got.tx_byte);
            check_field("data_valid", want.data_valid, got.data_valid);
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("data_index", want.data_index, got.data_index);
            check_field("commit", want.commit, got.commit);
            check_field("commit_address", want.commit_address, got.commit_address);
            check_field("done_res", want.done_res, got.done_res);
            check_field("status", want.status, got.status);
            check_field("last", want.last, got.last);
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------
   // Sends one request word. Valid stays high after the handshake so that
   // back-to-back words need no gap; the next call or hold_off may lower it.
   task automatic send_word(input logic [1:0] op, input logic [7:0] rx, input logic wok);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, wok, rx};
      do @(posedge clock); while (!req_tready);
      xmodem_rx_step(op, rx, wok);
      word_count++;
   endtask

   // Unused fields of a word carry random bits so that every rx_byte and write_ok bit toggles.
   task automatic send_start();
      send_word(OP_START, 8'($urandom), 1'($urandom));
   endtask

   task automatic send_tick();
      send_word(OP_TICK, 8'($urandom), 1'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(OP_BYTE, b, 1'($urandom));
   endtask

   task automatic send_write(input logic ok);
      send_word(OP_WRITE, 8'($urandom), ok);
   endtask

   task automatic hold_off();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Registers change only while the receiver is quiet: no word in flight,
   // every expected response delivered, and a settling wait for words that
   // caused no response.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      hold_off();
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_BASE_ADDRESS:  cfg_base           = value[19:0];
         REG_RETRY_LIMIT:   cfg_retries        = value[7:0];
         REG_PREAMBLE_WAIT: cfg_preamble_ticks = value[15:0];
         REG_BYTE_WAIT:     cfg_byte_ticks     = value[15:0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_config(input logic [31:0] base, input logic [31:0] retries,
                               input logic [31:0] pre_ticks, input logic [31:0] byte_ticks);
      write_csr(REG_BASE_ADDRESS, base);
      write_csr(REG_RETRY_LIMIT, retries);
      write_csr(REG_PREAMBLE_WAIT, pre_ticks);
      write_csr(REG_BYTE_WAIT, byte_ticks);
   endtask

   // One block: SOH, number, complement, payload and checksum. A clean block
   // is always good and has no ticks in it; otherwise the header or checksum
   // may be damaged, ticks may fall between bytes and a restart may cut in.
   task automatic send_block(input bit clean);
      logic [7:0] blk;
      logic [7:0] sum;
      logic [7:0] b;
      int         abort_at;
      blk      = (clean || $urandom_range(99) < 90) ? expect_blk : 8'($urandom);
      abort_at = (!clean && $urandom_range(99) < 4) ? int'($urandom_range(130)) : -1;
      sum      = '0;
      send_byte(CH_SOH);
      for (int pos = 0; pos <= int'(CHECKSUM_POS); pos++) begin
         if (rx_mode != MODE_BLOCK) return;
         if (pos == abort_at) begin
            send_start();
            return;
         end
         if (!clean && $urandom_range(99) < 3) begin
            repeat ($urandom_range(1, 3)) send_tick();
            if (rx_mode != MODE_BLOCK) return;
         end
         if (pos == 0) begin
            b = blk;
         end else if (pos == 1) begin
            b = (clean || $urandom_range(99) < 95) ? ~blk : 8'($urandom);
         end else if (pos < int'(CHECKSUM_POS)) begin
            b   = 8'($urandom);
            sum = sum + b;
         end else begin
            b = (clean || $urandom_range(99) < 90) ? sum : sum + 8'($urandom_range(1, 255));
         end
         send_byte(b);
      end
   endtask

   // One transfer from start to its end: mostly well-formed blocks with
   // random content, mixed with stray ticks, bad preambles and timeouts.
   task automatic run_session();
      int blocks;
      int pick;
      blocks = 0;
      send_start();
      while (rx_mode == MODE_WAIT) begin
         if ($urandom_range(99) < 15) repeat ($urandom_range(1, 3)) send_tick();
         if (rx_mode != MODE_WAIT) break;
         pick = $urandom_range(99);
         if (pick < 78 && blocks < 5 && word_count < word_budget) begin
            send_block(1'b0);
            blocks++;
            if (rx_mode == MODE_WRITE) begin
               // Words the flash-write wait does not expect are ignored.
               if ($urandom_range(99) < 10) send_byte(8'($urandom));
               if ($urandom_range(99) < 10) send_tick();
               send_write($urandom_range(99) < 88);
            end
         end else if (pick < 90) begin
            send_byte(CH_EOT);
         end else if (pick < 95) begin
            send_byte(8'($urandom));
         end else if (int'(cfg_preamble_ticks) * int'(cfg_retries) <= 300) begin
            while (rx_mode == MODE_WAIT) send_tick();
         end else begin
            send_byte(CH_EOT);
         end
      end
      if (rx_mode == MODE_DONE && $urandom_range(99) < 30) begin
         send_word(2'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   // Register settings for a stretch of transfers, extremes among them.
   task automatic pick_config();
      case ($urandom_range(5))
         0: apply_config($urandom_range(20'hFFFFF), 10, 5000, 1000);
         1: apply_config($urandom_range(20'hFFFFF), $urandom_range(1, 4),
                         $urandom_range(1, 6), $urandom_range(2, 8));
         2: apply_config(20'hFFFFF, 255, 16'hFFFF, 16'hFFFF);
         3: apply_config(0, 1, 1, 1);
         4: apply_config($urandom_range(20'hFFFFF), $urandom_range(2), 0, 0);
         default: apply_config($urandom, $urandom, $urandom, $urandom);
      endcase
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------
   // Words outside a transfer, the preamble cases and the field extremes.
   task automatic test_ignored_and_preamble();
      apply_config(20'h00BFF, 10, 5000, 1000);
      send_byte(CH_SOH);
      send_tick();
      send_write(1'b1);
      send_start();
      send_write(1'b0);
      send_byte(CH_EOT);
      send_byte(8'hFF);
      send_tick();
      send_start();
      send_byte(8'h00);
      send_start();
      send_byte(8'hFF);
   endtask

   // With no retries a start gives up at once without sending NAK.
   task automatic test_zero_retry_limit();
      apply_config(20'h12345, 0, 5000, 1000);
      send_start();
      send_tick();
   endtask

   // With zero wait ticks every tick is a timeout, both before the first
   // byte (NAK repeated) and inside a block (bad block).
   task automatic test_zero_wait_ticks();
      apply_config(20'hFFFFF, 2, 0, 0);
      send_start();
      send_tick();
      send_tick();
      send_start();
      send_byte(CH_SOH);
      send_tick();
      send_tick();
      send_tick();
   endtask

   task automatic test_random_transfers(input int n_words, input int req_pct,
                                        input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      word_budget  = word_count + n_words;
      while (word_count < word_budget) begin
         if ($urandom_range(99) < 40) pick_config();
         run_session();
      end
   endtask

   // Nine good blocks from the highest aligned address: the running address
   // wraps past the top of the address space and the last block commits at zero.
   task automatic test_address_wrap();
      apply_config(20'hFFFFF, 255, 16'hFFFF, 16'hFFFF);
      send_start();
      repeat (9) begin
         send_block(1'b1);
         send_write(1'b1);
      end
      send_byte(CH_EOT);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 21;
      rsp_idle_pct = 65;
      test_ignored_and_preamble();
      test_zero_retry_limit();
      test_zero_wait_ticks();
      test_random_transfers(90, 21, 65);
      test_random_transfers(90, 65, 21);
      test_random_transfers(90, 0, 0);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_address_wrap();

      // Drain the response queue, then give stray words time to show up.
      hold_off();
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: a run that hangs on a handshake ends here as a failure.
   initial begin
      #1_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
